### rtl/core/tksq_pkg.sv
`timescale 1ns / 1ps

package tksq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 5;
  localparam int ID_W        = 16;
  localparam int TIME_W      = 32;
  localparam int CTR_W       = 8;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } tksq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } tksq_status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tstamp;
    logic [CTR_W-1:0]  ctr;
  } tksq_entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } tksq_ctl_t;

  // true when x must leave strictly before y
  function automatic logic served_before(tksq_entry_t x, tksq_entry_t y);
    logic res;
    if (x.tstamp != y.tstamp) begin
      res = (x.tstamp < y.tstamp);
    end else begin
      res = (x.ctr > y.ctr);
    end
    return res;
  endfunction

endpackage

### rtl/core/tksq_if.sv
`timescale 1ns / 1ps

interface tksq_in_if;
  import tksq_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ID_W-1:0]   entry_id;
  logic [TIME_W-1:0] entry_time;
  logic [CTR_W-1:0]  entry_counter;

  modport source (output valid, output operation, output entry_id,
                  output entry_time, output entry_counter, input ready);
  modport sink (input valid, input operation, input entry_id,
                input entry_time, input entry_counter, output ready);
endinterface

interface tksq_out_if;
  import tksq_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ID_W-1:0]   head_id;
  logic [TIME_W-1:0] head_time;
  logic [CTR_W-1:0]  head_counter;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output head_id, output head_time,
                  output head_counter, output occupancy, input ready);
  modport sink (input valid, input status, input head_id, input head_time,
                input head_counter, input occupancy, output ready);
endinterface

### rtl/core/two_key_sorted_priority_queue.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload                                            | Handshake
// in_ch   | in  | operation, entry_id, entry_time, entry_counter     | valid/ready
// out_ch  | out | status, head_id, head_time, head_counter, occupancy | valid/ready
//
// One item per cycle unless out_ch stalls; a result is valid the next cycle.
// The cell row decides insert position in parallel and shifts all cells at once.
// Synchronous active-low reset empties the queue; slot payloads stay as is.
// in_ch.ready drops only while a result sits unclaimed in the output register.

module two_key_sorted_priority_queue (
  input logic       clk,
  input logic       rst_n,
  tksq_in_if.sink   in_ch,
  tksq_out_if.source out_ch
);
  import tksq_pkg::*;

  tksq_entry_t new_entry;
  tksq_entry_t cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_go;
  tksq_ctl_t ctl;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             full, empty, accept;

  logic              out_valid_r;
  tksq_status_t      status_r, status_nxt;
  tksq_entry_t       head_r, head_nxt;
  logic [OCC_W-1:0]  occ_r;

  assign new_entry.id     = in_ch.entry_id;
  assign new_entry.tstamp = in_ch.entry_time;
  assign new_entry.ctr    = in_ch.entry_counter;

  // a new item may enter whenever the output slot frees up this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  assign ctl.enq = accept && (in_ch.operation == OP_ENQ) && !full;
  assign ctl.deq = accept && (in_ch.operation == OP_DEQ) && !empty;

  // Cell row: slot 0 is the head. Enqueue shifts the tail run toward the
  // back; dequeue pulls every slot one step toward the head.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tksq_entry_t l_entry, r_entry;
    logic        l_valid, l_go, r_valid;

    if (i == 0) begin : g_first
      assign l_entry = new_entry;
      assign l_valid = 1'b1;
      assign l_go    = 1'b0;
    end else begin : g_mid
      assign l_entry = cell_entry[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_go    = cell_go[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_entry = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_entry = cell_entry[i+1];
      assign r_valid = cell_valid[i+1];
    end

    tksq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .left_entry (l_entry),
      .left_valid (l_valid),
      .left_go    (l_go),
      .right_entry(r_entry),
      .right_valid(r_valid),
      .entry      (cell_entry[i]),
      .valid      (cell_valid[i]),
      .go         (cell_go[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    head_nxt   = '0;
    if (in_ch.operation == OP_ENQ) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt = count_r - CNT_W'(1);
        head_nxt  = cell_entry[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      head_r   <= head_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.head_id      = head_r.id;
  assign out_ch.head_time    = head_r.tstamp;
  assign out_ch.head_counter = head_r.ctr;
  assign out_ch.occupancy    = occ_r;

endmodule

### rtl/core/tksq_cell.sv
`timescale 1ns / 1ps

module tksq_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tksq_pkg::tksq_ctl_t  ctl,
  input  tksq_pkg::tksq_entry_t new_entry,
  input  tksq_pkg::tksq_entry_t left_entry,
  input  logic                 left_valid,
  input  logic                 left_go,
  input  tksq_pkg::tksq_entry_t right_entry,
  input  logic                 right_valid,
  output tksq_pkg::tksq_entry_t entry,
  output logic                 valid,
  output logic                 go
);
  import tksq_pkg::*;

  tksq_entry_t entry_r, entry_nxt;
  logic        valid_r, valid_nxt;

  // go: new item belongs here or further toward the head; forms a tail run
  assign go = !valid_r || served_before(new_entry, entry_r);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctl.enq) begin
      valid_nxt = valid_r | left_valid;
      if (go) begin
        entry_nxt = left_go ? left_entry : new_entry;
      end
    end else if (ctl.deq) begin
      valid_nxt = right_valid;
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

### rtl/core/tksq_checker.sv
`timescale 1ns / 1ps

module tksq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_status,
  input logic [tksq_pkg::ID_W-1:0]  out_head_id,
  input logic [tksq_pkg::TIME_W-1:0] out_head_time,
  input logic [tksq_pkg::CTR_W-1:0] out_head_counter,
  input logic [tksq_pkg::OCC_W-1:0] out_occupancy
);
  import tksq_pkg::*;

  // every accepted item yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted item");

  // error results carry no head entry
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY || out_status == ST_FULL) |->
      out_head_id == '0 && out_head_time == '0 && out_head_counter == '0)
    else $error("error result with nonzero head");

  // empty error only when zero entries are held
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_occupancy == '0)
    else $error("empty status with nonzero occupancy");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_occupancy) && $stable(out_head_id))
    else $error("stalled result changed");

endmodule

bind two_key_sorted_priority_queue tksq_checker u_tksq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_head_id     (out_ch.head_id),
  .out_head_time   (out_ch.head_time),
  .out_head_counter(out_ch.head_counter),
  .out_occupancy   (out_ch.occupancy)
);

### test/tb_two_key_sorted_priority_queue.sv
`timescale 1ns / 1ps

module tb_two_key_sorted_priority_queue;
  import tksq_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 1450;
  localparam int MAX_WAIT      = 10;
  localparam int SIDE_IN       = 0;
  localparam int SIDE_OUT      = 1;

  // one expected result item
  typedef struct {
    tksq_status_t      status;
    logic [ID_W-1:0]   head_id;
    logic [TIME_W-1:0] head_time;
    logic [CTR_W-1:0]  head_counter;
    logic [OCC_W-1:0]  occupancy;
  } queue_result_t;

  logic clk;
  logic rst_n;

  tksq_in_if  in_bus ();
  tksq_out_if out_bus ();

  two_key_sorted_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus.sink),
    .out_ch (out_bus.source)
  );

  // Shadow copy of the sorted slot row; slot 0 is the head.
  tksq_entry_t   shadow_slots [QUEUE_DEPTH];
  int            shadow_held;
  queue_result_t pending_results [$];

  int mismatches;
  int cycle_count;
  int enq_ok_count;
  int deq_ok_count;
  int full_hits;
  int empty_hits;
  int burst_left [2];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor: applies one operation to the shadow queue and returns the
  // result item that the block must produce for it.
  // ---------------------------------------------------------------------
  function automatic queue_result_t apply_queue_op(tksq_op_t op, tksq_entry_t item);
    queue_result_t r;
    int            pos;
    int            i;
    r.status       = ST_OK;
    r.head_id      = '0;
    r.head_time    = '0;
    r.head_counter = '0;
    if (op == OP_ENQ) begin
      if (shadow_held >= QUEUE_DEPTH) begin
        // full: entry dropped, nothing moves
        r.status = ST_FULL;
        full_hits++;
      end else begin
        // new entry goes in front of the first held entry it strictly beats;
        // equal keys stay behind, so ties leave in arrival order
        pos = shadow_held;
        for (i = 0; i < shadow_held; i++) begin
          if (item.tstamp < shadow_slots[i].tstamp ||
              (item.tstamp == shadow_slots[i].tstamp &&
               item.ctr > shadow_slots[i].ctr)) begin
            pos = i;
            break;
          end
        end
        for (i = shadow_held; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos] = item;
        shadow_held++;
        enq_ok_count++;
      end
    end else begin
      if (shadow_held == 0) begin
        // empty: zero head fields, state untouched
        r.status = ST_EMPTY;
        empty_hits++;
      end else begin
        r.head_id      = shadow_slots[0].id;
        r.head_time    = shadow_slots[0].tstamp;
        r.head_counter = shadow_slots[0].ctr;
        for (i = 0; i + 1 < shadow_held; i++) shadow_slots[i] = shadow_slots[i+1];
        shadow_held--;
        deq_ok_count++;
      end
    end
    r.occupancy = shadow_held[OCC_W-1:0];
    return r;
  endfunction

  function automatic tksq_entry_t mk_entry(logic [ID_W-1:0] id, logic [TIME_W-1:0] t,
                                           logic [CTR_W-1:0] c);
    tksq_entry_t e;
    e.id     = id;
    e.tstamp = t;
    e.ctr    = c;
    return e;
  endfunction

  // Random per-item wait, with occasional bursts of back-to-back
  // items so that full-rate stretches are exercised too.
  function automatic int draw_wait(int side);
    int w;
    if (burst_left[side] > 0) begin
      burst_left[side]--;
      w = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      burst_left[side] = $urandom_range(20, 60);
      w = 0;
    end else begin
      w = $urandom_range(0, MAX_WAIT);
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Sends one item. Called right after the previous acceptance edge; valid
  // is left high after acceptance so a zero-wait item follows with no drop.
  // ---------------------------------------------------------------------
  task automatic send_op(tksq_op_t op, tksq_entry_t item);
    int gap;
    gap = draw_wait(SIDE_IN);
    @(negedge clk);
    repeat (gap) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.operation     <= op;
    in_bus.entry_id      <= item.id;
    in_bus.entry_time    <= item.tstamp;
    in_bus.entry_counter <= item.ctr;
    do @(posedge clk); while (!in_bus.ready);
    // accepted at this edge; result shows up in the next cycle at the earliest
    pending_results.push_back(apply_queue_op(op, item));
  endtask

  // random key biased toward small values and the top of the range so ties are common
  function automatic logic [TIME_W-1:0] draw_time();
    logic [TIME_W-1:0] t;
    case ($urandom_range(0, 9))
      0:       t = '0;
      1:       t = '1;
      2, 3, 4: t = $urandom_range(0, 3);
      5:       t = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: t = $urandom;
    endcase
    return t;
  endfunction

  function automatic logic [CTR_W-1:0] draw_counter();
    logic [CTR_W-1:0] c;
    case ($urandom_range(0, 7))
      0:       c = '0;
      1:       c = '1;
      2, 3, 4: c = CTR_W'($urandom_range(0, 2));
      default: c = CTR_W'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // dequeue from an empty queue, payload fields at both extremes
  task automatic test_empty_dequeue();
    send_op(OP_DEQ, mk_entry('0, '0, '0));
    send_op(OP_DEQ, mk_entry('1, '1, '1));
  endtask

  // fill to capacity with extremes and ties, try one more enqueue, then dequeue four
  task automatic test_fill_and_overflow();
    send_op(OP_ENQ, mk_entry(16'h0001, 32'd100, 8'd5));
    send_op(OP_ENQ, mk_entry(16'h0002, 32'd100, 8'd5));      // exact tie
    send_op(OP_ENQ, mk_entry(16'h0003, 32'd100, 8'd200));    // same time, higher ctr
    send_op(OP_ENQ, mk_entry(16'h0000, 32'd0, 8'd0));
    send_op(OP_ENQ, mk_entry(16'hFFFF, 32'hFFFF_FFFF, 8'd255));
    send_op(OP_ENQ, mk_entry(16'h0006, 32'hFFFF_FFFF, 8'd0));
    send_op(OP_ENQ, mk_entry(16'h0007, 32'd0, 8'd255));
    send_op(OP_ENQ, mk_entry(16'h0008, 32'd100, 8'd5));      // third of the tie
    send_op(OP_ENQ, mk_entry(16'h0009, 32'd50, 8'd0));
    send_op(OP_ENQ, mk_entry(16'h000A, 32'hFFFF_FFFE, 8'd128));
    send_op(OP_ENQ, mk_entry(16'h5555, 32'h7FFF_FFFF, 8'h7F));
    send_op(OP_ENQ, mk_entry(16'hAAAA, 32'h8000_0000, 8'h80));
    send_op(OP_ENQ, mk_entry(16'h000D, 32'h8000_0000, 8'h81));
    send_op(OP_ENQ, mk_entry(16'h000E, 32'hFFFF_FFFF, 8'd255)); // tie with a held max
    send_op(OP_ENQ, mk_entry(16'h000F, 32'd0, 8'd0));          // tie with a held min
    send_op(OP_ENQ, mk_entry(16'h0010, 32'h5555_AAAA, 8'h55));
    // would tie the current head, but the queue is full so it is dropped
    send_op(OP_ENQ, mk_entry(16'hFFFF, 32'd0, 8'd255));
    repeat (4) send_op(OP_DEQ, mk_entry(ID_W'($urandom), $urandom, CTR_W'($urandom)));
  endtask

  // Random traffic in phases with different enqueue bias, so occupancy
  // sweeps repeatedly between empty and full.
  task automatic test_random_traffic(int n_items);
    int       enq_pct;
    int       k;
    tksq_op_t op;
    enq_pct = 50;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       enq_pct = 85;
          1:       enq_pct = 15;
          default: enq_pct = 55;
        endcase
      end
      op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
      send_op(op, mk_entry(ID_W'($urandom), draw_time(), draw_counter()));
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // ---------------------------------------------------------------------
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = draw_wait(SIDE_OUT);
      repeat (gap) begin
        out_bus.ready <= 1'b0;
        @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", 32'(out_bus.status),
                        32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.status !== want.status)
          report_mismatch("status", 32'(out_bus.status), 32'(want.status));
        if (out_bus.head_id !== want.head_id)
          report_mismatch("head_id", 32'(out_bus.head_id), 32'(want.head_id));
        if (out_bus.head_time !== want.head_time)
          report_mismatch("head_time", out_bus.head_time, want.head_time);
        if (out_bus.head_counter !== want.head_counter)
          report_mismatch("head_counter", 32'(out_bus.head_counter),
                          32'(want.head_counter));
        if (out_bus.occupancy !== want.occupancy)
          report_mismatch("occupancy", 32'(out_bus.occupancy), 32'(want.occupancy));
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.operation     = OP_ENQ;
    in_bus.entry_id      = '0;
    in_bus.entry_time    = '0;
    in_bus.entry_counter = '0;
    out_bus.ready        = 1'b0;
    shadow_held          = 0;
    mismatches           = 0;
    enq_ok_count         = 0;
    deq_ok_count         = 0;
    full_hits            = 0;
    empty_hits           = 0;
    burst_left[SIDE_IN]  = 0;
    burst_left[SIDE_OUT] = 0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_dequeue();
    test_fill_and_overflow();
    test_random_traffic(RANDOM_ITEMS);

    @(negedge clk);
    in_bus.valid <= 1'b0;

    // drain, then keep watching for any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d enqueues, %0d dequeues, %0d drops on full, %0d empty reads",
             enq_ok_count, deq_ok_count, full_hits, empty_hits);
    $display("back-pressure on both sides, %0d cycles", cycle_count);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/tksq_pkg.sv
rtl/core/tksq_if.sv
rtl/core/tksq_cell.sv
rtl/core/two_key_sorted_priority_queue.sv
rtl/core/tksq_checker.sv
test/tb_two_key_sorted_priority_queue.sv
